@@ hw/rtl/rhpm_pkg.sv @@
// ----------------------------------------------------------------------------
// rhpm_pkg: shared types and constants of the rolling hash pattern matcher
// Register map codes, field widths, window control/status structs and the
// pattern byte select helper.
// ----------------------------------------------------------------------------
package rhpm_pkg;

    localparam int unsigned MAX_PATTERN = 8;
    localparam int unsigned INDEX_BITS  = 16;
    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned LEN_BITS    = 4;
    localparam int unsigned MOD_BITS    = 12;
    localparam int unsigned SEEN_BITS   = 17;
    localparam int unsigned PAT_BITS    = MAX_PATTERN * BYTE_BITS;
    localparam int unsigned WIN_IDX     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [SEEN_BITS-1:0] SEEN_MAX = {SEEN_BITS{1'b1}};
    localparam int unsigned IDX_SAT_INT =
        (INDEX_BITS >= SEEN_BITS) ? ((1 << SEEN_BITS) - 1) : ((1 << INDEX_BITS) - 1);
    localparam logic [SEEN_BITS-1:0] IDX_SAT = IDX_SAT_INT[SEEN_BITS-1:0];

    // register indexes
    localparam logic [1:0] REG_PATTERN = 2'd0;
    localparam logic [1:0] REG_LENGTH  = 2'd1;
    localparam logic [1:0] REG_MODULUS = 2'd2;

    typedef struct packed {
        logic clear;
        logic shift;
    } rhpm_win_ctrl_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] leaving;
        logic                 bytes_equal;
    } rhpm_win_stat_t;

    function automatic logic [BYTE_BITS-1:0] pat_byte(input logic [PAT_BITS-1:0] pat,
                                                       input logic [WIN_IDX-1:0]  j);
        pat_byte = pat[BYTE_BITS*j +: BYTE_BITS];
    endfunction

endpackage

@@ hw/rtl/rolling_hash_pattern_matcher.sv @@
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher: streaming Rabin-Karp pattern search
// Top level with the APB register file, the sequencer and the result stage.
// ----------------------------------------------------------------------------
// Each text byte goes through ST_WH, ST_LPQ, ST_HORN and ST_CHECK while the
// window holds fewer bytes than the pattern length; once it is full, ST_MUL
// forms the leaving-byte product and ST_SUB subtracts it before ST_HORN. The
// stored window hash is reduced in ST_WH_RUN when it is not below the modulus,
// and the leading power in ST_LPQ_RUN when it is not, which happens only after
// a modulus change mid-text. A byte with the start flag first rebuilds the
// leading power and the pattern hash. The hash arithmetic runs on one modular
// step unit that shifts in one bit per cycle. s_ready is high only between bytes;
// a result waits in an output register, and the next byte is taken while it
// waits. Registers sit at byte addresses 0, 8 and 16.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_matcher
    import rhpm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_BITS-1:0]  s_text_byte,
    input  logic                  s_start_req,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INDEX_BITS-1:0] m_match_index
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_LP_INIT = 4'd1;
    localparam logic [3:0] ST_LP_RUN  = 4'd2;
    localparam logic [3:0] ST_PH_RUN  = 4'd3;
    localparam logic [3:0] ST_WH      = 4'd4;
    localparam logic [3:0] ST_WH_RUN  = 4'd5;
    localparam logic [3:0] ST_LPQ     = 4'd6;
    localparam logic [3:0] ST_LPQ_RUN = 4'd7;
    localparam logic [3:0] ST_MUL     = 4'd8;
    localparam logic [3:0] ST_SUB     = 4'd9;
    localparam logic [3:0] ST_HORN    = 4'd10;
    localparam logic [3:0] ST_CHECK   = 4'd11;

    // configuration
    logic [PAT_BITS-1:0] pattern_reg;
    logic [LEN_BITS-1:0] length_reg;
    logic [MOD_BITS-1:0] modulus_reg;
    logic                cfg_wr;
    logic [1:0]          cfg_idx;

    // datapath and sequencer
    logic [3:0]            state_reg, state_next;
    logic [MOD_BITS-1:0]   acc_reg, acc_next;
    logic [MOD_BITS-1:0]   sh_reg, sh_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic [WIN_IDX-1:0]    jc_reg, jc_next;
    logic [BYTE_BITS-1:0]  byte_reg, byte_next;
    logic [MOD_BITS-1:0]   t_reg, t_next;
    logic [MOD_BITS-1:0]   lpq_reg, lpq_next;
    logic [MOD_BITS-1:0]   wh_reg, wh_next;
    logic [MOD_BITS-1:0]   ph_reg, ph_next;
    logic [MOD_BITS-1:0]   lp_reg, lp_next;
    logic [SEEN_BITS-1:0]  seen_reg, seen_next;
    logic                  out_valid_reg, out_valid_next;
    logic [INDEX_BITS-1:0] out_idx_reg, out_idx_next;

    logic [LEN_BITS-1:0]   len_eff;
    logic [LEN_BITS-1:0]   len_m1;
    logic [MOD_BITS-1:0]   q_eff;
    logic                  accept;
    logic                  last_bit;
    logic                  full;
    logic [SEEN_BITS-1:0]  idx_raw;
    logic [SEEN_BITS-1:0]  idx_sat;
    logic [MOD_BITS:0]     diff_wrap;
    logic [MOD_BITS-1:0]   diff;

    logic                  step_bit;
    logic [MOD_BITS-1:0]   step_add;
    logic [MOD_BITS-1:0]   step_out;

    rhpm_win_ctrl_t        win_ctrl;
    rhpm_win_stat_t        win_stat;

    // ---------------- register file ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= LEN_BITS'(1);
            modulus_reg <= MOD_BITS'(37);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PATTERN: pattern_reg <= pwdata[PAT_BITS-1:0];
                REG_LENGTH:  length_reg  <= pwdata[LEN_BITS-1:0];
                REG_MODULUS: modulus_reg <= pwdata[MOD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PATTERN: prdata = 64'(pattern_reg);
            REG_LENGTH:  prdata = 64'(length_reg);
            REG_MODULUS: prdata = 64'(modulus_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------- effective settings ----------------
    always_comb begin
        if (length_reg == '0) begin
            len_eff = LEN_BITS'(1);
        end else if (length_reg > LEN_BITS'(MAX_PATTERN)) begin
            len_eff = LEN_BITS'(MAX_PATTERN);
        end else begin
            len_eff = length_reg;
        end
        len_m1 = len_eff - LEN_BITS'(1);
        q_eff  = (modulus_reg == '0) ? MOD_BITS'(1) : modulus_reg;
    end

    // ---------------- shared modular step ----------------
    always_comb begin
        step_bit = sh_reg[MOD_BITS-1];
        step_add = '0;
        if (state_reg == ST_LP_RUN) begin
            step_bit = 1'b0;
        end else if (state_reg == ST_MUL) begin
            step_bit = 1'b0;
            step_add = sh_reg[MOD_BITS-1] ? lpq_reg : '0;
        end
    end

    rhpm_modstep u_step (
        .r_in    (acc_reg),
        .bit_in  (step_bit),
        .addend  (step_add),
        .modulus (q_eff),
        .r_out   (step_out)
    );

    rhpm_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .byte_in (byte_reg),
        .len_eff (len_eff),
        .pattern (pattern_reg),
        .stat    (win_stat)
    );

    // ---------------- sequencer ----------------
    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign m_valid       = out_valid_reg;
    assign m_match_index = out_idx_reg;

    always_comb begin
        last_bit  = (cnt_reg == 6'd1);
        full      = (seen_reg >= SEEN_BITS'(len_eff));
        idx_raw   = seen_reg - SEEN_BITS'(len_eff);
        idx_sat   = (idx_raw > IDX_SAT) ? IDX_SAT : idx_raw;
        diff_wrap = {1'b0, t_reg} + {1'b0, q_eff} - {1'b0, acc_reg};
        diff      = (t_reg >= acc_reg) ? (t_reg - acc_reg) : diff_wrap[MOD_BITS-1:0];
    end

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sh_next        = sh_reg;
        cnt_next       = cnt_reg;
        jc_next        = jc_reg;
        byte_next      = byte_reg;
        t_next         = t_reg;
        lpq_next       = lpq_reg;
        wh_next        = wh_reg;
        ph_next        = ph_reg;
        lp_next        = lp_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        win_ctrl       = '0;

        // drop the result once it is taken
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    byte_next = s_text_byte;
                    if (s_start_req) begin
                        wh_next        = '0;
                        seen_next      = '0;
                        win_ctrl.clear = 1'b1;
                        state_next     = ST_LP_INIT;
                    end else begin
                        state_next = ST_WH;
                    end
                end
            end
            ST_LP_INIT: begin
                acc_next   = (q_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                cnt_next   = {len_m1[2:0], 3'b000};
                state_next = ST_LP_RUN;
            end
            ST_LP_RUN: begin
                if (cnt_reg == '0) begin
                    lp_next    = acc_reg;
                    acc_next   = '0;
                    jc_next    = '0;
                    sh_next    = {pat_byte(pattern_reg, '0), 4'b0000};
                    cnt_next   = 6'd8;
                    state_next = ST_PH_RUN;
                end else begin
                    acc_next = step_out;
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            ST_PH_RUN: begin
                acc_next = step_out;
                sh_next  = {sh_reg[MOD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (last_bit) begin
                    if (jc_reg == len_m1[WIN_IDX-1:0]) begin
                        ph_next    = step_out;
                        state_next = ST_WH;
                    end else begin
                        jc_next  = jc_reg + WIN_IDX'(1);
                        sh_next  = {pat_byte(pattern_reg, jc_reg + WIN_IDX'(1)), 4'b0000};
                        cnt_next = 6'd8;
                    end
                end
            end
            ST_WH: begin
                if (wh_reg < q_eff) begin
                    t_next     = wh_reg;
                    state_next = ST_LPQ;
                end else begin
                    acc_next   = '0;
                    sh_next    = wh_reg;
                    cnt_next   = 6'(MOD_BITS);
                    state_next = ST_WH_RUN;
                end
            end
            ST_WH_RUN: begin
                acc_next = step_out;
                sh_next  = {sh_reg[MOD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (last_bit) begin
                    t_next     = step_out;
                    state_next = ST_LPQ;
                end
            end
            ST_LPQ: begin
                if (!full) begin
                    acc_next   = t_reg;
                    sh_next    = {byte_reg, 4'b0000};
                    cnt_next   = 6'd8;
                    state_next = ST_HORN;
                end else if (lp_reg < q_eff) begin
                    lpq_next   = lp_reg;
                    acc_next   = '0;
                    sh_next    = {win_stat.leaving, 4'b0000};
                    cnt_next   = 6'd8;
                    state_next = ST_MUL;
                end else begin
                    acc_next   = '0;
                    sh_next    = lp_reg;
                    cnt_next   = 6'(MOD_BITS);
                    state_next = ST_LPQ_RUN;
                end
            end
            ST_LPQ_RUN: begin
                acc_next = step_out;
                sh_next  = {sh_reg[MOD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (last_bit) begin
                    lpq_next   = step_out;
                    acc_next   = '0;
                    sh_next    = {win_stat.leaving, 4'b0000};
                    cnt_next   = 6'd8;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                acc_next = step_out;
                sh_next  = {sh_reg[MOD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (last_bit) begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB: begin
                // remove the leaving byte's weight from the hash
                acc_next   = diff;
                sh_next    = {byte_reg, 4'b0000};
                cnt_next   = 6'd8;
                state_next = ST_HORN;
            end
            ST_HORN: begin
                acc_next = step_out;
                sh_next  = {sh_reg[MOD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (last_bit) begin
                    wh_next        = step_out;
                    win_ctrl.shift = 1'b1;
                    if (seen_reg != SEEN_MAX) begin
                        seen_next = seen_reg + SEEN_BITS'(1);
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (full && (wh_reg == ph_reg) && win_stat.bytes_equal) begin
                    // hold until the output stage is free
                    if (!out_valid_reg || m_ready) begin
                        out_valid_next = 1'b1;
                        out_idx_next   = idx_sat[INDEX_BITS-1:0];
                        state_next     = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            wh_reg        <= '0;
            ph_reg        <= '0;
            lp_reg        <= MOD_BITS'(1);
            seen_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wh_reg        <= wh_next;
            ph_reg        <= ph_next;
            lp_reg        <= lp_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        sh_reg      <= sh_next;
        cnt_reg     <= cnt_next;
        jc_reg      <= jc_next;
        byte_reg    <= byte_next;
        t_reg       <= t_next;
        lpq_reg     <= lpq_next;
        out_idx_reg <= out_idx_next;
    end

endmodule

@@ hw/rtl/rhpm_modstep.sv @@
// ----------------------------------------------------------------------------
// rhpm_modstep: one step of the serial modular reduction unit
// Computes ((2*r + bit) mod q + addend) mod q for r < q and addend < q, with
// two compare-and-subtract stages.
// ----------------------------------------------------------------------------
module rhpm_modstep
    import rhpm_pkg::*;
(
    input  logic [MOD_BITS-1:0] r_in,
    input  logic                bit_in,
    input  logic [MOD_BITS-1:0] addend,
    input  logic [MOD_BITS-1:0] modulus,
    output logic [MOD_BITS-1:0] r_out
);

    logic [MOD_BITS:0]   dbl;
    logic [MOD_BITS:0]   dbl_red;
    logic [MOD_BITS:0]   sum;
    logic [MOD_BITS:0]   sum_red;

    always_comb begin
        dbl     = {r_in, bit_in};
        dbl_red = (dbl >= {1'b0, modulus}) ? (dbl - {1'b0, modulus}) : dbl;
        sum     = dbl_red + {1'b0, addend};
        sum_red = (sum >= {1'b0, modulus}) ? (sum - {1'b0, modulus}) : sum;
        r_out   = sum_red[MOD_BITS-1:0];
    end

endmodule

@@ hw/rtl/rhpm_window.sv @@
// ----------------------------------------------------------------------------
// rhpm_window: text byte window and byte-by-byte pattern compare
// Holds the last MAX_PATTERN text bytes, gives the byte leaving a window of
// the active length and flags an exact match against the pattern.
// ----------------------------------------------------------------------------
module rhpm_window
    import rhpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rhpm_win_ctrl_t       ctrl,
    input  logic [BYTE_BITS-1:0] byte_in,
    input  logic [LEN_BITS-1:0]  len_eff,
    input  logic [PAT_BITS-1:0]  pattern,
    output rhpm_win_stat_t       stat
);

    logic [BYTE_BITS-1:0] win_reg  [MAX_PATTERN];
    logic [BYTE_BITS-1:0] win_next [MAX_PATTERN];
    logic [LEN_BITS-1:0]  len_m1;
    logic [MAX_PATTERN-1:0] hit;

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            win_next[k] = win_reg[k];
        end
        if (ctrl.clear) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win_next[k] = '0;
            end
        end else if (ctrl.shift) begin
            for (int k = MAX_PATTERN - 1; k > 0; k--) begin
                win_next[k] = win_reg[k-1];
            end
            win_next[0] = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // entry k is pattern byte m-1-k; entries past the length always agree
    always_comb begin
        len_m1 = len_eff - LEN_BITS'(1);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (LEN_BITS'(k) < len_eff) begin
                hit[k] = (win_reg[k] ==
                          pat_byte(pattern, WIN_IDX'(len_m1 - LEN_BITS'(k))));
            end else begin
                hit[k] = 1'b1;
            end
        end
        stat.bytes_equal = &hit;
        stat.leaving     = win_reg[len_m1[WIN_IDX-1:0]];
    end

endmodule

@@ hw/rtl/rhpm_checker.sv @@
// ----------------------------------------------------------------------------
// rhpm_checker: port-level checks of the rolling hash pattern matcher
// Watches the byte and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rhpm_checker
    import rhpm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [INDEX_BITS-1:0] m_match_index
);

    // a beat keeps the block busy right after it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("byte input ready right after a beat");

    // a byte is not finished before its shortest path of work is through
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##11 !s_ready)
        else $error("byte finished too early");

    // a result only appears at the end of a byte's work
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without work behind it");

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_match_index))
        else $error("stalled result beat changed");

endmodule

bind rolling_hash_pattern_matcher rhpm_checker u_rhpm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_match_index (m_match_index)
);
